// File: rtl/core/owtm_pkg.sv
// Shared types, register map and command codes for the 1-Wire temperature master.
`default_nettype none
package owtm_pkg;

  localparam int unsigned TICK_W  = 10;
  localparam int unsigned START_W = 6;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned REG_IDX_W = 3;

  // bytes fetched from the scratchpad by a temperature read (2..9)
  localparam logic [3:0] SCRATCHPAD_BYTES = 4'd9;

  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_CONVERT_T  = 8'h44;
  localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

  localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RESET = 3'd1;
  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TEMP  = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRES_SAMPLE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SLOT        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_LOW   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RECOVERY    = 3'd6;

  typedef struct packed {
    logic [TICK_W-1:0]  reset_low;
    logic [TICK_W-1:0]  pres_sample;
    logic [TICK_W-1:0]  reset_tail;
    logic [TICK_W-1:0]  slot;
    logic [START_W-1:0] start_low;
    logic [TICK_W-1:0]  read_sample;
    logic [TICK_W-1:0]  recovery;
  } cfg_t;

  typedef struct packed {
    logic       line_low;
    logic       busy;
    logic       done;
    logic       present;
    logic [7:0] rx_byte;
    logic       rx_valid;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/owtm_cfg_regs.sv
// APB slot-timing register file.
`default_nettype none
module owtm_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [owtm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [owtm_pkg::DATA_W-1:0]  pwdata,
  output logic      [owtm_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output owtm_pkg::cfg_t                    cfg
);

  owtm_pkg::cfg_t                       cfg_r;
  logic [owtm_pkg::REG_IDX_W-1:0]       idx;
  logic                                 wr_en;

  assign idx    = paddr[owtm_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low   <= 10'd480;
      cfg_r.pres_sample <= 10'd70;
      cfg_r.reset_tail  <= 10'd410;
      cfg_r.slot        <= 10'd60;
      cfg_r.start_low   <= 6'd2;
      cfg_r.read_sample <= 10'd15;
      cfg_r.recovery    <= 10'd5;
    end else if (wr_en) begin
      case (idx)
        owtm_pkg::REG_RESET_LOW:   cfg_r.reset_low   <= pwdata[owtm_pkg::TICK_W-1:0];
        owtm_pkg::REG_PRES_SAMPLE: cfg_r.pres_sample <= pwdata[owtm_pkg::TICK_W-1:0];
        owtm_pkg::REG_RESET_TAIL:  cfg_r.reset_tail  <= pwdata[owtm_pkg::TICK_W-1:0];
        owtm_pkg::REG_SLOT:        cfg_r.slot        <= pwdata[owtm_pkg::TICK_W-1:0];
        owtm_pkg::REG_START_LOW:   cfg_r.start_low   <= pwdata[owtm_pkg::START_W-1:0];
        owtm_pkg::REG_READ_SAMPLE: cfg_r.read_sample <= pwdata[owtm_pkg::TICK_W-1:0];
        owtm_pkg::REG_RECOVERY:    cfg_r.recovery    <= pwdata[owtm_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      owtm_pkg::REG_RESET_LOW:   prdata[owtm_pkg::TICK_W-1:0]  = cfg_r.reset_low;
      owtm_pkg::REG_PRES_SAMPLE: prdata[owtm_pkg::TICK_W-1:0]  = cfg_r.pres_sample;
      owtm_pkg::REG_RESET_TAIL:  prdata[owtm_pkg::TICK_W-1:0]  = cfg_r.reset_tail;
      owtm_pkg::REG_SLOT:        prdata[owtm_pkg::TICK_W-1:0]  = cfg_r.slot;
      owtm_pkg::REG_START_LOW:   prdata[owtm_pkg::START_W-1:0] = cfg_r.start_low;
      owtm_pkg::REG_READ_SAMPLE: prdata[owtm_pkg::TICK_W-1:0]  = cfg_r.read_sample;
      owtm_pkg::REG_RECOVERY:    prdata[owtm_pkg::TICK_W-1:0]  = cfg_r.recovery;
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/owtm_engine.sv
// Bus sequencer: reset/presence, bit slots, byte shifting and the temperature-read sequence.
`default_nettype none
module owtm_engine #(
  parameter logic [3:0] SCRATCHPAD_BYTES = owtm_pkg::SCRATCHPAD_BYTES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic [owtm_pkg::ACT_W-1:0]  action,
  input  wire logic [7:0]                  tx_byte,
  input  wire logic                        line_in,
  input  wire owtm_pkg::cfg_t              cfg,
  output owtm_pkg::res_t                   res,
  output logic [7:0]                       raw_low,
  output logic [7:0]                       raw_high
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_RLOW, PH_RWAIT, PH_RTAIL, PH_WSLOT, PH_RSLOT, PH_WREC, PH_RREC
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [owtm_pkg::TICK_W-1:0]   tick_r, tick_nxt;
  logic [2:0]                    bit_r, bit_nxt;
  logic [7:0]                    shift_r, shift_nxt;
  logic [3:0]                    seq_r, seq_nxt;
  logic [3:0]                    nbytes_r, nbytes_nxt;
  logic [7:0]                    rawl_r, rawl_nxt;
  logic [7:0]                    rawh_r, rawh_nxt;
  logic                          pres_r, pres_nxt;
  logic [owtm_pkg::ACT_W-1:0]    act_r, act_nxt;
  logic [7:0]                    lrx_r, lrx_nxt;
  owtm_pkg::res_t                res_r, res_nxt;

  logic [owtm_pkg::TICK_W-1:0]   len, samp, rlow_lim, rwait_lim, rtail_lim;

  assign len       = (cfg.slot == '0) ? 10'd1 : cfg.slot;
  assign samp      = (cfg.read_sample < len) ? cfg.read_sample : len - 10'd1;
  assign rlow_lim  = (cfg.reset_low == '0) ? 10'd1 : cfg.reset_low;
  assign rwait_lim = (cfg.pres_sample == '0) ? 10'd1 : cfg.pres_sample;
  assign rtail_lim = (cfg.reset_tail == '0) ? 10'd1 : cfg.reset_tail;

  always_comb begin
    logic slot_end, after, unit_fin, was_rd, busy, low, done, rxv;
    logic [owtm_pkg::TICK_W:0] tinc;
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    seq_nxt    = seq_r;
    nbytes_nxt = nbytes_r;
    rawl_nxt   = rawl_r;
    rawh_nxt   = rawh_r;
    pres_nxt   = pres_r;
    act_nxt    = act_r;
    lrx_nxt    = lrx_r;
    slot_end   = 1'b0;
    after      = 1'b0;
    unit_fin   = 1'b0;
    was_rd     = 1'b0;
    low        = 1'b0;
    done       = 1'b0;
    rxv        = 1'b0;

    // command start; the same tick is its first tick
    if (phase_r == PH_IDLE &&
        action inside {[owtm_pkg::ACT_RESET:owtm_pkg::ACT_TEMP]}) begin
      act_nxt    = action;
      seq_nxt    = '0;
      nbytes_nxt = '0;
      tick_nxt   = '0;
      bit_nxt    = '0;
      if (action == owtm_pkg::ACT_WRITE) begin
        shift_nxt = tx_byte;
        phase_nxt = PH_WSLOT;
      end else if (action == owtm_pkg::ACT_READ) begin
        shift_nxt = '0;
        phase_nxt = PH_RSLOT;
      end else begin
        phase_nxt = PH_RLOW;
      end
    end
    busy = (phase_nxt != PH_IDLE);
    tinc = {1'b0, tick_nxt} + 11'd1;

    case (phase_nxt)
      PH_RLOW: begin
        low = 1'b1;
        tick_nxt = tinc[owtm_pkg::TICK_W-1:0];
        if (tinc >= {1'b0, rlow_lim}) begin
          phase_nxt = PH_RWAIT;
          tick_nxt  = '0;
        end
      end
      PH_RWAIT: begin
        tick_nxt = tinc[owtm_pkg::TICK_W-1:0];
        if (tinc >= {1'b0, rwait_lim}) begin
          phase_nxt = PH_RTAIL;
          tick_nxt  = '0;
        end
      end
      PH_RTAIL: begin
        if (tick_nxt == '0) pres_nxt = ~line_in;
        tick_nxt = tinc[owtm_pkg::TICK_W-1:0];
        if (tinc >= {1'b0, rtail_lim}) unit_fin = 1'b1;
      end
      PH_WSLOT: begin
        low = shift_nxt[bit_nxt] ? (tick_nxt < {4'd0, cfg.start_low}) : 1'b1;
        tick_nxt = tinc[owtm_pkg::TICK_W-1:0];
        if (tinc >= {1'b0, len}) slot_end = 1'b1;
      end
      PH_RSLOT: begin
        was_rd = 1'b1;
        low = (tick_nxt < {4'd0, cfg.start_low});
        if (tick_nxt == samp && line_in) shift_nxt[bit_nxt] = 1'b1;
        tick_nxt = tinc[owtm_pkg::TICK_W-1:0];
        if (tinc >= {1'b0, len}) slot_end = 1'b1;
      end
      PH_WREC, PH_RREC: begin
        was_rd   = (phase_nxt == PH_RREC);
        tick_nxt = tinc[owtm_pkg::TICK_W-1:0];
        if (tinc >= {1'b0, cfg.recovery}) begin
          tick_nxt = '0;
          after    = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase

    if (slot_end) begin
      tick_nxt = '0;
      if (cfg.recovery != '0) phase_nxt = was_rd ? PH_RREC : PH_WREC;
      else after = 1'b1;
    end

    if (after) begin
      if (bit_nxt != 3'd7) begin
        bit_nxt   = bit_nxt + 3'd1;
        tick_nxt  = '0;
        phase_nxt = was_rd ? PH_RSLOT : PH_WSLOT;
      end else begin
        unit_fin = 1'b1;
      end
    end

    if (unit_fin) begin
      if (was_rd) begin
        lrx_nxt = shift_nxt;
        rxv     = 1'b1;
      end
      if (act_nxt != owtm_pkg::ACT_TEMP) begin
        done = 1'b1; phase_nxt = PH_IDLE; tick_nxt = '0; act_nxt = owtm_pkg::ACT_TICK;
      end else begin
        // next unit of the temperature read; tick and bit restart in every branch
        tick_nxt = '0;
        bit_nxt  = '0;
        case (seq_nxt)
          4'd0: begin seq_nxt = 4'd1; shift_nxt = owtm_pkg::CMD_SKIP_ROM;   phase_nxt = PH_WSLOT; end
          4'd1: begin seq_nxt = 4'd2; shift_nxt = owtm_pkg::CMD_CONVERT_T;  phase_nxt = PH_WSLOT; end
          4'd2: begin seq_nxt = 4'd3; phase_nxt = PH_RLOW; end
          4'd3: begin seq_nxt = 4'd4; shift_nxt = owtm_pkg::CMD_SKIP_ROM;   phase_nxt = PH_WSLOT; end
          4'd4: begin seq_nxt = 4'd5; shift_nxt = owtm_pkg::CMD_READ_SCRPD; phase_nxt = PH_WSLOT; end
          4'd5: begin
            seq_nxt = 4'd6; nbytes_nxt = '0; shift_nxt = '0; phase_nxt = PH_RSLOT;
          end
          default: begin
            if (nbytes_nxt == 4'd0) rawl_nxt = shift_nxt;
            else if (nbytes_nxt == 4'd1) rawh_nxt = shift_nxt;
            nbytes_nxt = nbytes_nxt + 4'd1;
            if (nbytes_nxt >= SCRATCHPAD_BYTES) begin
              done = 1'b1; phase_nxt = PH_IDLE; act_nxt = owtm_pkg::ACT_TICK;
            end else begin
              shift_nxt = '0; phase_nxt = PH_RSLOT;
            end
          end
        endcase
      end
    end

    res_nxt.line_low = low;
    res_nxt.busy     = busy;
    res_nxt.done     = done;
    res_nxt.present  = pres_nxt;
    res_nxt.rx_byte  = lrx_nxt;
    res_nxt.rx_valid = rxv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      bit_r    <= '0;
      shift_r  <= '0;
      seq_r    <= '0;
      nbytes_r <= '0;
      rawl_r   <= '0;
      rawh_r   <= '0;
      pres_r   <= 1'b0;
      act_r    <= owtm_pkg::ACT_TICK;
      lrx_r    <= '0;
      res_r    <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      seq_r    <= seq_nxt;
      nbytes_r <= nbytes_nxt;
      rawl_r   <= rawl_nxt;
      rawh_r   <= rawh_nxt;
      pres_r   <= pres_nxt;
      act_r    <= act_nxt;
      lrx_r    <= lrx_nxt;
      res_r    <= res_nxt;
    end
  end

  assign res      = res_r;
  assign raw_low  = rawl_r;
  assign raw_high = rawh_r;

endmodule
`default_nettype wire

// File: rtl/core/owtm_temp_conv.sv
// Raw scratchpad temperature to whole degrees Celsius and Fahrenheit.
`default_nettype none
module owtm_temp_conv (
  input  wire logic [7:0]         raw_low,
  input  wire logic [7:0]         raw_high,
  output logic signed [7:0]       celsius,
  output logic signed [9:0]       fahrenheit
);

  logic signed [16:0] raw_ext;
  logic signed [16:0] half;
  logic signed [11:0] c9;
  logic        [10:0] mag;
  logic        [27:0] prod;
  logic        [10:0] quot;
  logic signed [11:0] fq;

  // halve toward zero: add one to negative values before the arithmetic shift
  assign raw_ext = signed'({raw_high[7], raw_high, raw_low});
  assign half    = (raw_ext + signed'({16'd0, raw_high[7]})) >>> 1;

  always_comb begin
    if (half > 17'sd127)        celsius = 8'sd127;
    else if (half < -17'sd128)  celsius = -8'sd128;
    else                        celsius = half[7:0];
  end

  // |c*9| / 5 via reciprocal 52429/2^18, exact below 2^13
  assign c9   = 12'(celsius) * 12'sd9;
  assign mag  = c9[11] ? 11'(-c9) : c9[10:0];
  assign prod = {17'd0, mag} * 28'd52429;
  assign quot = {1'b0, prod[27:18]};
  assign fq   = c9[11] ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
  assign fahrenheit = 10'(fq + 12'sd32);

endmodule
`default_nettype wire

// File: rtl/core/one_wire_temperature_master_core.sv
// Top level of the 1-Wire temperature master: handshake stages, registers, sequencer.
`default_nettype none
// 1-Wire bus master, one input item per bus tick (nominally 1 us). Each item
// carries the sampled DQ level and an optional command (bus reset, write byte,
// read byte, temperature read); exactly one result item comes back per input
// item, with the DQ drive, busy/done, presence, read byte and the temperature
// of the last completed temperature read. One item is taken per clock while the
// output is not stalled: an item waits in the input register until the sequencer
// advances, updating its state and the result register, and the result register
// frees the input side whenever the result is taken or absent. Slot timing comes
// from the APB registers at byte addresses 0x00..0x18, which must be written
// only while no items are in flight; the block does not enforce this.
module one_wire_temperature_master_core #(
  parameter logic [3:0] SCRATCHPAD_BYTES = owtm_pkg::SCRATCHPAD_BYTES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [owtm_pkg::ACT_W-1:0]  in_action,
  input  wire logic [7:0]                  in_tx_byte,
  input  wire logic                        in_line_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_line_low,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic                             out_device_present,
  output logic [7:0]                       out_rx_byte,
  output logic                             out_rx_byte_valid,
  output logic signed [7:0]                out_temp_celsius,
  output logic signed [9:0]                out_temp_fahrenheit,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [owtm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [owtm_pkg::DATA_W-1:0] pwdata,
  output logic      [owtm_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  logic                        in_vld_r;
  logic [owtm_pkg::ACT_W-1:0]  act_r;
  logic [7:0]                  tx_r;
  logic                        line_r;
  logic                        out_vld_r;
  logic                        adv;
  owtm_pkg::cfg_t              cfg;
  owtm_pkg::res_t              res;
  logic [7:0]                  raw_low, raw_high;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (adv) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      act_r  <= in_action;
      tx_r   <= in_tx_byte;
      line_r <= in_line_in;
    end
  end

  owtm_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owtm_engine #(
    .SCRATCHPAD_BYTES (SCRATCHPAD_BYTES)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .action   (act_r),
    .tx_byte  (tx_r),
    .line_in  (line_r),
    .cfg      (cfg),
    .res      (res),
    .raw_low  (raw_low),
    .raw_high (raw_high)
  );

  // raw bytes change only with the result register, so these hold while stalled
  owtm_temp_conv u_conv (
    .raw_low    (raw_low),
    .raw_high   (raw_high),
    .celsius    (out_temp_celsius),
    .fahrenheit (out_temp_fahrenheit)
  );

  assign out_valid          = out_vld_r;
  assign out_line_low       = res.line_low;
  assign out_busy_res       = res.busy;
  assign out_done_res       = res.done;
  assign out_device_present = res.present;
  assign out_rx_byte        = res.rx_byte;
  assign out_rx_byte_valid  = res.rx_valid;

endmodule
`default_nettype wire
